// ===== rtl/escaped_frame_receiver_crc8_top_defines.svh =====
// ----------------------------------------------------------------------------
// escaped frame receiver assertion macros
// shared assertion forms for the frame receiver; ASSERT_OFF compiles them out
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_RECEIVER_CRC8_TOP_DEFINES_SVH
`define ESCAPED_FRAME_RECEIVER_CRC8_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define EFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("frame receiver check failed");

// next-cycle implication
`define EFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("frame receiver check failed");

`else

`define EFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define EFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/efr_crc8_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_crc8_pkg
// framing byte codes and the crc-8 (reflected 0x8c) byte update
// ----------------------------------------------------------------------------
package efr_crc8_pkg;

	typedef logic [7:0] byte_t;

	localparam byte_t HDR_BYTE = 8'hAC;
	localparam byte_t FTR_BYTE = 8'hAD;
	localparam byte_t ESC_BYTE = 8'hAE;
	localparam byte_t ESC_MASK = 8'h80;
	localparam byte_t CRC_POLY = 8'h8C;

	// one byte through the reflected crc, lsb first
	function automatic byte_t crc8_next(input byte_t crc, input byte_t b);
		byte_t c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/efr_crc8_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_crc8_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module efr_crc8_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 35
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, holds its data between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/escaped_frame_receiver_crc8_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_receiver_crc8_top
// byte-stuffed frame receiver: unescapes and stores frame bytes, checks the
// trailing crc-8 on the footer and plays a good payload out of the store
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// rx        in         rx_valid / rx_stall     rx_byte
// payload   out        payload_valid /         payload_byte, payload_length,
//                      payload_stall           last_item
//
// each raw byte takes one cycle while a frame is being received.
// a good frame with a non-empty payload holds rx off while
// the store is read back through its single registered read port.
// an empty payload gives its one beat straight from the footer cycle.
// reset clears control state only; the store needs no clearing pass.
// rx is also held off while a waiting payload beat is stalled.
// ----------------------------------------------------------------------------
`include "escaped_frame_receiver_crc8_top_defines.svh"

module escaped_frame_receiver_crc8_top #(
	parameter int MAX_FRAME_BYTES = 35
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       payload_valid,
	input  logic       payload_stall,
	output logic [7:0] payload_byte,
	output logic [5:0] payload_length,
	output logic       last_item
);

	localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
	localparam int AW = $clog2(MAX_FRAME_BYTES);

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_DATA,
		ST_ESC,
		ST_EMIT
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           len_q;
	logic [CW-1:0]           issue_idx_q;
	logic                    rd_pend_q;
	logic                    pend_last_q;
	efr_crc8_pkg::byte_t     crc_all_q;
	efr_crc8_pkg::byte_t     crc_bl_q;
	efr_crc8_pkg::byte_t     last_byte_q;
	logic                    out_valid_q;
	efr_crc8_pkg::byte_t     out_byte_q;
	logic [5:0]              out_len_q;
	logic                    out_last_q;

	logic                    rx_accept;
	logic                    out_free;
	logic                    is_store;
	logic                    has_room;
	logic                    wr_en;
	efr_crc8_pkg::byte_t     store_byte;
	logic                    rd_en;
	logic                    load;
	efr_crc8_pkg::byte_t     rd_data;
	logic [CW-1:0]           foot_len;
	logic                    foot_ok;
	logic                    out_set;
	logic [CW+5:0]           emit_len_ext;

	// handshakes
	assign out_free  = !out_valid_q || !payload_stall;
	assign rx_stall  = (state_q == ST_EMIT) || (out_valid_q && payload_stall);
	assign rx_accept = rx_valid && !rx_stall;

	// byte to store and store write
	assign store_byte = (state_q == ST_ESC) ? (rx_byte ^ efr_crc8_pkg::ESC_MASK) : rx_byte;
	assign is_store   = (state_q == ST_ESC) ||
		((state_q == ST_DATA) && (rx_byte != efr_crc8_pkg::FTR_BYTE) &&
		 (rx_byte != efr_crc8_pkg::ESC_BYTE));
	assign has_room   = count_q < CW'(MAX_FRAME_BYTES);
	assign wr_en      = rx_accept && is_store && has_room;

	// readback: issue when nothing waits or the waiting beat moves on
	assign load  = (state_q == ST_EMIT) && rd_pend_q && out_free;
	assign rd_en = (state_q == ST_EMIT) && (issue_idx_q < len_q) && (!rd_pend_q || out_free);

	// payload length, masked to six bits
	assign foot_len     = count_q - CW'(1);
	assign emit_len_ext = {6'd0, len_q};

	// footer crc check and output beat launch
	assign foot_ok = (count_q != '0) && (last_byte_q == crc_bl_q);
	assign out_set = load ||
		(rx_accept && (state_q == ST_DATA) && (rx_byte == efr_crc8_pkg::FTR_BYTE) &&
		 foot_ok && (foot_len == '0));

	efr_crc8_ram #(
		.WIDTH (8),
		.DEPTH (MAX_FRAME_BYTES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (store_byte),
		.rd_en   (rd_en),
		.rd_addr (issue_idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// frame state machine and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_HUNT;
			count_q     <= '0;
			len_q       <= '0;
			issue_idx_q <= '0;
			rd_pend_q   <= 1'b0;
			pend_last_q <= 1'b0;
			crc_all_q   <= '0;
			crc_bl_q    <= '0;
			last_byte_q <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_len_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (!payload_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_HUNT: begin
					if (rx_accept && (rx_byte == efr_crc8_pkg::HDR_BYTE)) begin
						state_q <= ST_DATA;
					end
				end
				ST_DATA, ST_ESC: begin
					if (rx_accept) begin
						if (is_store) begin
							if (has_room) begin
								count_q     <= count_q + CW'(1);
								crc_bl_q    <= crc_all_q;
								crc_all_q   <= efr_crc8_pkg::crc8_next(crc_all_q, store_byte);
								last_byte_q <= store_byte;
								state_q     <= ST_DATA;
							end else begin
								state_q   <= ST_HUNT;
								count_q   <= '0;
								crc_all_q <= '0;
								crc_bl_q  <= '0;
							end
						end else if (rx_byte == efr_crc8_pkg::ESC_BYTE) begin
							state_q <= ST_ESC;
						end else begin
							// footer: check crc, then start over
							count_q   <= '0;
							crc_all_q <= '0;
							crc_bl_q  <= '0;
							if (foot_ok && (foot_len != '0)) begin
								state_q     <= ST_EMIT;
								len_q       <= foot_len;
								issue_idx_q <= '0;
								rd_pend_q   <= 1'b0;
							end else begin
								state_q <= ST_HUNT;
								if (foot_ok) begin
									out_byte_q <= '0;
									out_len_q  <= '0;
									out_last_q <= 1'b1;
								end
							end
						end
					end
				end
				ST_EMIT: begin
					if (load) begin
						out_byte_q <= rd_data;
						out_len_q  <= emit_len_ext[5:0];
						out_last_q <= pend_last_q;
						if (pend_last_q) begin
							state_q <= ST_HUNT;
						end
					end
					if (rd_en) begin
						issue_idx_q <= issue_idx_q + CW'(1);
						rd_pend_q   <= 1'b1;
						pend_last_q <= (issue_idx_q + CW'(1)) == len_q;
					end else if (load) begin
						rd_pend_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_HUNT;
				end
			endcase
		end
	end

	assign payload_valid  = out_valid_q;
	assign payload_byte   = out_byte_q;
	assign payload_length = out_len_q;
	assign last_item      = out_last_q;

	// checks
	`EFR_ASSERT_IMP(a_pend_in_emit, clk, arst_n, rd_pend_q, state_q == ST_EMIT)
	`EFR_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(MAX_FRAME_BYTES))
	`EFR_ASSERT_IMP(a_issue_bound, clk, arst_n, state_q == ST_EMIT, issue_idx_q <= len_q)
	`EFR_ASSERT_IMP(a_no_rw_overlap, clk, arst_n, rd_en, !wr_en)
	`EFR_ASSERT_NXT(a_last_ends_run, clk, arst_n, load && pend_last_q, state_q == ST_HUNT)

	// emitted length is the stored length masked to six bits
	`EFR_ASSERT_NXT(a_len_match, clk, arst_n, load, out_len_q == $past(emit_len_ext[5:0]))

endmodule

// ===== test/efr_crc8_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_crc8_checker
// follows the escaped frame receiver from the outside: it rebuilds the frames
// from the accepted rx beats, predicts the payload beats of every good frame
// and compares each accepted payload beat with the oldest prediction
// ----------------------------------------------------------------------------
package efr_tb_crc_pkg;

	// crc-8 update, one data bit at a time, lsb first
	function automatic efr_crc8_pkg::byte_t crc8_bitwise(input efr_crc8_pkg::byte_t crc,
	                                                     input efr_crc8_pkg::byte_t data);
		efr_crc8_pkg::byte_t r;
		logic                fb;
		r = crc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ data[i];
			r  = {1'b0, r[7:1]};
			if (fb) begin
				r = r ^ efr_crc8_pkg::CRC_POLY;
			end
		end
		return r;
	endfunction

endpackage

module efr_crc8_checker #(
	parameter int MAX_FRAME_BYTES = 35
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	input  logic       rx_stall,
	input  logic [7:0] rx_byte,
	input  logic       payload_valid,
	input  logic       payload_stall,
	input  logic [7:0] payload_byte,
	input  logic [5:0] payload_length,
	input  logic       last_item,
	output int         fail_count,
	output int         pending_beats,
	output int         beats_checked
);

	typedef enum logic [1:0] {
		HUNTING      = 2'd0,
		IN_FRAME     = 2'd1,
		AFTER_ESCAPE = 2'd2
	} rx_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic [5:0] length;
		logic       last;
	} payload_beat_t;

	rx_phase_t           phase;
	int unsigned         fill;
	efr_crc8_pkg::byte_t frame_buf [MAX_FRAME_BYTES];
	efr_crc8_pkg::byte_t crc_all;
	efr_crc8_pkg::byte_t crc_prev;
	payload_beat_t       beat_q [$];

	initial begin
		fail_count    = 0;
		pending_beats = 0;
		beats_checked = 0;
	end

	// back to header search with an empty frame
	task automatic restart_hunt();
		phase    = HUNTING;
		fill     = 0;
		crc_all  = '0;
		crc_prev = '0;
	endtask

	// store one unescaped byte, or drop the frame when the store is full
	task automatic store_frame_byte(input efr_crc8_pkg::byte_t b);
		if (fill < MAX_FRAME_BYTES) begin
			frame_buf[fill] = b;
			fill++;
			crc_prev = crc_all;
			crc_all  = efr_tb_crc_pkg::crc8_bitwise(crc_all, b);
			phase    = IN_FRAME;
		end else begin
			restart_hunt();
		end
	endtask

	// queue the payload beats of a frame whose trailing crc matched
	task automatic queue_payload();
		int unsigned   len;
		logic [5:0]    len6;
		payload_beat_t beat;
		len  = fill - 1;
		len6 = len[5:0];
		if (len == 0) begin
			beat = '{data: 8'h00, length: 6'd0, last: 1'b1};
			beat_q.push_back(beat);
		end else begin
			for (int unsigned i = 0; i < len; i++) begin
				beat = '{data: frame_buf[i], length: len6, last: (i + 1 == len)};
				beat_q.push_back(beat);
			end
		end
	endtask

	// one accepted rx beat through the deframer
	task automatic predict_rx(input efr_crc8_pkg::byte_t b);
		case (phase)
			IN_FRAME: begin
				if (b == efr_crc8_pkg::FTR_BYTE) begin
					if (fill >= 1 && fill <= MAX_FRAME_BYTES &&
					    frame_buf[fill - 1] == crc_prev) begin
						queue_payload();
					end
					restart_hunt();
				end else if (b == efr_crc8_pkg::ESC_BYTE) begin
					phase = AFTER_ESCAPE;
				end else begin
					store_frame_byte(b);
				end
			end
			AFTER_ESCAPE: begin
				store_frame_byte(b ^ efr_crc8_pkg::ESC_MASK);
			end
			default: begin
				if (b == efr_crc8_pkg::HDR_BYTE) begin
					restart_hunt();
					phase = IN_FRAME;
				end else begin
					phase = HUNTING;
				end
			end
		endcase
	endtask

	// compare one accepted payload beat with the oldest prediction
	task automatic check_beat();
		payload_beat_t want;
		if (beat_q.size() == 0) begin
			$error("unexpected payload beat: payload_byte %0h payload_length %0d last_item %0b",
			       payload_byte, payload_length, last_item);
			fail_count++;
		end else begin
			want = beat_q.pop_front();
			beats_checked++;
			if (payload_byte !== want.data) begin
				$error("payload_byte mismatch: expected %0h, actual %0h", want.data, payload_byte);
				fail_count++;
			end
			if (payload_length !== want.length) begin
				$error("payload_length mismatch: expected %0d, actual %0d",
				       want.length, payload_length);
				fail_count++;
			end
			if (last_item !== want.last) begin
				$error("last_item mismatch: expected %0b, actual %0b", want.last, last_item);
				fail_count++;
			end
		end
	endtask

	// watch both channels on the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_hunt();
			beat_q.delete();
		end else begin
			if (rx_valid && !rx_stall) begin
				predict_rx(rx_byte);
			end
			if (payload_valid && !payload_stall) begin
				check_beat();
			end
		end
		pending_beats = beat_q.size();
	end

endmodule

// ===== test/tb_escaped_frame_receiver_crc8_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escaped_frame_receiver_crc8_top
// drives byte-stuffed frames into the receiver: hand-picked corner frames
// first, then short random good, corrupted and empty frames mixed with line
// noise, with idle bursts on rx and stall bursts on the payload side;
// the checker beside the block predicts and compares every payload beat
// ----------------------------------------------------------------------------
module tb_escaped_frame_receiver_crc8_top;

	localparam int MAX_FRAME_BYTES = 35;
	localparam int TOTAL_BYTES     = 120;
	localparam int QUIET_FROM      = 100;

	typedef enum logic [1:0] {
		FRAME_GOOD,
		FRAME_BAD_CRC,
		FRAME_NO_BODY
	} frame_kind_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       rx_valid      = 1'b0;
	logic [7:0] rx_byte       = 8'h00;
	logic       payload_stall = 1'b0;
	logic       rx_stall;
	logic       payload_valid;
	logic [7:0] payload_byte;
	logic [5:0] payload_length;
	logic       last_item;

	int fail_count;
	int pending_beats;
	int beats_checked;

	logic [7:0]          cycle_cnt = '0;
	logic                calm;
	logic                quiet     = 1'b0;
	efr_crc8_pkg::byte_t frame_body [$];
	int                  rx_beats    = 0;
	int                  noise_bytes = 0;
	int                  frames_sent = 0;

	escaped_frame_receiver_crc8_top #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_valid      (rx_valid),
		.rx_stall      (rx_stall),
		.rx_byte       (rx_byte),
		.payload_valid (payload_valid),
		.payload_stall (payload_stall),
		.payload_byte  (payload_byte),
		.payload_length(payload_length),
		.last_item     (last_item)
	);

	efr_crc8_checker #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_valid      (rx_valid),
		.rx_stall      (rx_stall),
		.rx_byte       (rx_byte),
		.payload_valid (payload_valid),
		.payload_stall (payload_stall),
		.payload_byte  (payload_byte),
		.payload_length(payload_length),
		.last_item     (last_item),
		.fail_count    (fail_count),
		.pending_beats (pending_beats),
		.beats_checked (beats_checked)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// every fourth stretch of cycle_cnt, where its top two bits are set, runs with no idling at all
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1'b1;
	end
	assign calm = (cycle_cnt[7:6] == 2'b11);

	// payload stall bursts of random length
	initial begin
		int burst;
		burst = 0;
		forever begin
			@(negedge clk);
			if (burst > 0) begin
				burst--;
			end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(1, 8);
			end
			payload_stall <= (burst > 0);
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// one rx beat, possibly after an idle burst; entered and left at a falling edge
	task automatic send_byte(input efr_crc8_pkg::byte_t b);
		if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (rx_stall) @(posedge clk);
		@(negedge clk);
		rx_beats++;
	endtask

	// header, stuffed body with trailing crc, footer
	task automatic send_frame(input frame_kind_t kind, input int esc_pct);
		efr_crc8_pkg::byte_t crc;
		efr_crc8_pkg::byte_t s;
		frames_sent++;
		send_byte(efr_crc8_pkg::HDR_BYTE);
		if (kind != FRAME_NO_BODY) begin
			crc = '0;
			foreach (frame_body[i]) crc = efr_tb_crc_pkg::crc8_bitwise(crc, frame_body[i]);
			if (kind == FRAME_BAD_CRC) begin
				crc = crc ^ efr_crc8_pkg::byte_t'($urandom_range(1, 255));
			end
			frame_body.push_back(crc);
			foreach (frame_body[i]) begin
				s = frame_body[i];
				if (s == efr_crc8_pkg::FTR_BYTE || s == efr_crc8_pkg::ESC_BYTE ||
				    $urandom_range(0, 99) < esc_pct) begin
					send_byte(efr_crc8_pkg::ESC_BYTE);
					send_byte(s ^ efr_crc8_pkg::ESC_MASK);
				end else begin
					send_byte(s);
				end
			end
		end
		send_byte(efr_crc8_pkg::FTR_BYTE);
	endtask

	task automatic load_random_body(input int len);
		frame_body.delete();
		repeat (len) frame_body.push_back(efr_crc8_pkg::byte_t'($urandom_range(0, 255)));
	endtask

	// payload of framing codes and their escaped images
	task automatic load_code_body();
		frame_body.delete();
		frame_body.push_back(8'h00);
		frame_body.push_back(8'hFF);
		frame_body.push_back(efr_crc8_pkg::HDR_BYTE);
		frame_body.push_back(efr_crc8_pkg::FTR_BYTE);
		frame_body.push_back(efr_crc8_pkg::ESC_BYTE);
		frame_body.push_back(efr_crc8_pkg::HDR_BYTE ^ efr_crc8_pkg::ESC_MASK);
		frame_body.push_back(efr_crc8_pkg::FTR_BYTE ^ efr_crc8_pkg::ESC_MASK);
		frame_body.push_back(efr_crc8_pkg::ESC_BYTE ^ efr_crc8_pkg::ESC_MASK);
		frame_body.push_back(efr_crc8_pkg::ESC_MASK);
		frame_body.push_back(8'h7F);
	endtask

	// stimulus
	initial begin
		int pick;
		int len;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// bytes other than a header are ignored while hunting
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(efr_crc8_pkg::FTR_BYTE);
		send_byte(efr_crc8_pkg::ESC_BYTE);
		send_byte(8'h55);
		noise_bytes += 5;

		// footer with nothing stored
		send_frame(FRAME_NO_BODY, 0);

		// empty payload: crc byte only
		frame_body.delete();
		send_frame(FRAME_GOOD, 0);

		// single-byte payloads at both extremes, the second fully escaped
		frame_body.delete();
		frame_body.push_back(8'h00);
		send_frame(FRAME_GOOD, 0);
		frame_body.delete();
		frame_body.push_back(8'hFF);
		send_frame(FRAME_GOOD, 100);

		// framing codes inside the payload, only the necessary escapes, header as data
		load_code_body();
		send_frame(FRAME_GOOD, 0);

		// longest payload the store holds
		load_random_body(MAX_FRAME_BYTES - 1);
		send_frame(FRAME_GOOD, 0);

		// hold rx back until the whole payload has come out
		rx_valid <= 1'b0;
		@(negedge clk);
		while (pending_beats != 0) @(negedge clk);

		// one byte too many drops the frame
		load_random_body(MAX_FRAME_BYTES);
		send_frame(FRAME_GOOD, 0);

		// corrupted crc straight after the overflow
		load_random_body(2);
		send_frame(FRAME_BAD_CRC, 0);

		// short random frames and noise
		while (rx_beats < TOTAL_BYTES) begin
			if (rx_beats >= QUIET_FROM) begin
				quiet = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				load_random_body($urandom_range(0, 6));
				send_frame(FRAME_GOOD, $urandom_range(0, 30));
			end else if (pick < 75) begin
				load_random_body($urandom_range(0, 6));
				send_frame(FRAME_BAD_CRC, $urandom_range(0, 30));
			end else if (pick < 85) begin
				send_frame(FRAME_NO_BODY, 0);
			end else begin
				// line noise, then two footers to close whatever it opened
				len = $urandom_range(1, 4);
				repeat (len) send_byte(efr_crc8_pkg::byte_t'($urandom_range(0, 255)));
				send_byte(efr_crc8_pkg::FTR_BYTE);
				send_byte(efr_crc8_pkg::FTR_BYTE);
				noise_bytes += len + 2;
			end
		end

		// drain
		rx_valid <= 1'b0;
		@(negedge clk);
		while (pending_beats != 0) @(negedge clk);
		repeat (40) @(negedge clk);

		$display("run covered %0d frames in %0d rx beats (%0d noise), including empty,",
		         frames_sent, rx_beats, noise_bytes);
		$display("full-length, overflowing, bad-crc and escaped frames; %0d payload beats checked",
		         beats_checked);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
